// File: rtl/core/md5s_pkg.sv
// ----------------------------------------------------------------------------
// md5s_pkg
// Shared types and constants for the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5s_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;

    // One block handed from the front to the back.
    typedef struct packed {
        logic [511:0] blk;    // word 0 in bits 31:0
        logic         fin;    // last block of a message: emit digest
    } t_blk;

    function automatic logic [31:0] step_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hD76AA478;  6'd1: k = 32'hE8C7B756;
            6'd2: k = 32'h242070DB;  6'd3: k = 32'hC1BDCEEE;
            6'd4: k = 32'hF57C0FAF;  6'd5: k = 32'h4787C62A;
            6'd6: k = 32'hA8304613;  6'd7: k = 32'hFD469501;
            6'd8: k = 32'h698098D8;  6'd9: k = 32'h8B44F7AF;
            6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
            6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
            6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
            6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
            6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
            6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
            6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
            6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
            6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
            6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
            6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
            6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
            6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
            6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
            6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
            6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
            6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
            6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
            6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
            6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
            6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
            6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
            6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
            6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
            6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
            6'd62: k = 32'h2AD7D2BB; default: k = 32'hEB86D391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] step_rot(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/core/md5s_if.sv
// ----------------------------------------------------------------------------
// md5s_in_if / md5s_out_if
// Valid/ready channels for message items and digest words.
// ----------------------------------------------------------------------------
interface md5s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
    modport source (output valid, data_byte, byte_valid, last_byte, input ready);
    modport sink   (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface md5s_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/core/md5_stream_hash.sv
// ----------------------------------------------------------------------------
// md5_stream_hash
// MD5 over a byte stream: one item per cycle while a block fills and no finished block waits.
// ----------------------------------------------------------------------------
// The front packs the byte of each accepted item with byte_valid set and hands
// each full 64-byte block to the compression unit, which loads the block, runs
// one MD5 step per cycle and then updates the chain. The front keeps taking
// bytes for the next block meanwhile. At message end the front stalls one
// extra block when the length needs a second pad block; the digest then
// leaves as four words.
module md5_stream_hash import md5s_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    md5s_in_if.sink     i_in,
    md5s_out_if.source  o_out
);

    t_blk blk;
    logic blk_valid;
    logic blk_ready;

    md5s_front u_front (
        .i_clk, .i_rst_n, .i_in,
        .o_blk(blk), .o_blk_valid(blk_valid), .i_blk_ready(blk_ready)
    );

    md5s_back u_back (
        .i_clk, .i_rst_n,
        .i_blk(blk), .i_blk_valid(blk_valid), .o_blk_ready(blk_ready), .o_out
    );

endmodule

// File: rtl/core/md5s_front.sv
// ----------------------------------------------------------------------------
// md5s_front
// Packs bytes into a block, counts length, pads and pushes finished blocks.
// ----------------------------------------------------------------------------
module md5s_front import md5s_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    md5s_in_if.sink     i_in,
    output t_blk        o_blk,
    output logic        o_blk_valid,
    input  logic        i_blk_ready
);

    typedef enum logic [1:0] {S_FILL, S_PADLEN} t_state;

    t_state        r_state;
    logic [511:0]  r_buf;
    logic [63:0]   r_bits;
    logic          r_bv;
    t_blk          r_blk;

    logic [5:0]    pos;
    logic [511:0]  pad_buf;
    logic [511:0]  len_buf;
    logic [63:0]   bits_next;
    logic          acc;

    assign pos       = r_bits[8:3];
    assign bits_next = r_bits + 64'd8;
    assign acc       = i_in.valid && i_in.ready;

    // Output slot must be free before any item is accepted.
    assign i_in.ready  = (r_state == S_FILL) && (!r_bv || i_blk_ready);
    assign o_blk       = r_blk;
    assign o_blk_valid = r_bv;

    always_comb begin
        logic [5:0]  p;
        logic [63:0] bc;
        logic [511:0] b;
        b  = r_buf;
        p  = pos;
        bc = r_bits;
        if (i_in.byte_valid) begin
            b[{p, 3'b000} +: 8] = i_in.data_byte;
            p  = p + 6'd1;
            bc = bits_next;
        end
        for (int k = 0; k < 64; k++) begin
            if (6'(k) == p && !(p == 6'd0 && i_in.byte_valid && pos == 6'd63))
                b[k*8 +: 8] = PAD_BYTE;
            else if (6'(k) > p)
                b[k*8 +: 8] = 8'h00;
        end
        // block just filled: pad starts a fresh block
        if (i_in.byte_valid && pos == 6'd63) begin
            b = '0;
            b[7:0] = PAD_BYTE;
        end
        pad_buf = b;
        len_buf = {bc, b[447:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_bits  <= '0;
            r_bv    <= 1'b0;
        end else begin
            if (r_bv && i_blk_ready)
                r_bv <= 1'b0;
            unique case (r_state)
                S_FILL: if (acc) begin
                    if (i_in.byte_valid) begin
                        r_buf[{pos, 3'b000} +: 8] <= i_in.data_byte;
                        r_bits <= bits_next;
                    end
                    if (i_in.last_byte) begin
                        if (i_in.byte_valid && pos == 6'd63) begin
                            r_blk.blk <= {i_in.data_byte, r_buf[503:0]};
                            r_blk.fin <= 1'b0;
                            r_bv      <= 1'b1;
                            r_buf     <= {r_bits + 64'd8, pad_buf[447:0]};
                            r_state   <= S_PADLEN;
                        end else if ((i_in.byte_valid ? pos + 6'd1 : pos) >= LEN_POS) begin
                            r_blk.blk <= pad_buf;
                            r_blk.fin <= 1'b0;
                            r_bv      <= 1'b1;
                            r_buf     <= {(i_in.byte_valid ? bits_next : r_bits), 448'd0};
                            r_state   <= S_PADLEN;
                        end else begin
                            r_blk.blk <= len_buf;
                            r_blk.fin <= 1'b1;
                            r_bv      <= 1'b1;
                            r_bits    <= '0;
                        end
                    end else if (i_in.byte_valid && pos == 6'd63) begin
                        r_blk.blk <= {i_in.data_byte, r_buf[503:0]};
                        r_blk.fin <= 1'b0;
                        r_bv      <= 1'b1;
                    end
                end
                S_PADLEN: if (!r_bv || i_blk_ready) begin
                    r_blk.blk <= r_buf;
                    r_blk.fin <= 1'b1;
                    r_bv      <= 1'b1;
                    r_bits    <= '0;
                    r_state   <= S_FILL;
                end
                default: r_state <= S_FILL;
            endcase
        end
    end

    a_len_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PADLEN) |-> r_bv) else $error("pad state without pending block");
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.last_byte && r_state == S_FILL) |=> (r_bv && (r_bits == 64'd0
            || r_state == S_PADLEN))) else $error("message end not taken");
    a_no_acc_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FILL) |-> !i_in.ready) else $error("accepted during padding");

endmodule

// File: rtl/core/md5s_back.sv
// ----------------------------------------------------------------------------
// md5s_back
// 64-step MD5 compression, one step a cycle, then chain update and, for a last block, digest word output.
// ----------------------------------------------------------------------------
module md5s_back import md5s_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_blk        i_blk,
    input  logic        i_blk_valid,
    output logic        o_blk_ready,
    md5s_out_if.source  o_out
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_ADD, S_EMIT} t_state;

    t_state       r_state;
    logic [31:0]  r_w [16];
    logic [31:0]  r_ch [4];
    logic [31:0]  r_a, r_b, r_c, r_d;
    logic [5:0]   r_step;
    logic         r_fin;
    logic [1:0]   r_idx;

    logic [31:0]  f, sum, rot;
    logic [3:0]   g;
    logic [4:0]   s;

    always_comb begin
        unique case (r_step[5:4])
            2'd0: begin f = (r_b & r_c) | (~r_b & r_d); g = r_step[3:0]; end
            2'd1: begin f = (r_b & r_d) | (r_c & ~r_d); g = 4'(5*r_step + 1); end
            2'd2: begin f = r_b ^ r_c ^ r_d;            g = 4'(3*r_step + 5); end
            default: begin f = r_c ^ (r_b | ~r_d);      g = 4'(7*r_step); end
        endcase
        s   = step_rot(r_step);
        sum = r_a + f + r_w[g] + step_k(r_step);
        rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    assign o_blk_ready       = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_EMIT);
    assign o_out.digest_word = r_ch[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_idx   <= '0;
            r_ch[0] <= IV_A; r_ch[1] <= IV_B; r_ch[2] <= IV_C; r_ch[3] <= IV_D;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_blk_valid) begin
                    for (int k = 0; k < 16; k++) r_w[k] <= i_blk.blk[k*32 +: 32];
                    r_fin <= i_blk.fin;
                    r_a <= r_ch[0]; r_b <= r_ch[1]; r_c <= r_ch[2]; r_d <= r_ch[3];
                    r_step  <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_a <= r_d; r_b <= r_b + rot; r_c <= r_b; r_d <= r_c;
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    r_ch[0] <= r_ch[0] + r_a; r_ch[1] <= r_ch[1] + r_b;
                    r_ch[2] <= r_ch[2] + r_c; r_ch[3] <= r_ch[3] + r_d;
                    r_idx   <= '0;
                    r_state <= r_fin ? S_EMIT : S_IDLE;
                end
                S_EMIT: if (o_out.ready) begin
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        r_ch[0] <= IV_A; r_ch[1] <= IV_B;
                        r_ch[2] <= IV_C; r_ch[3] <= IV_D;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_step_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_step == 6'd63) |=> (r_state == S_ADD))
        else $error("compression overran");
    a_emit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && r_idx != 2'd3) |=> (o_out.valid
            && r_idx == $past(r_idx) + 2'd1)) else $error("digest order");
    a_iv_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && r_idx == 2'd3) |=> (r_ch[0] == IV_A))
        else $error("chain not restarted");

endmodule
